[rtl/pad_pkg.sv]
// ----------------------------------------------------------------------------
// pad_pkg: shared types and constants of the ASCII PLC response deframer
// Character codes, result status codes, item payload types and the
// checksum hex-digit encoder.
// ----------------------------------------------------------------------------
package pad_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_FRAME = 128;
  localparam int DEF_CHANNELS  = 64;

  // Header characters kept per frame
  localparam int HDR_LEN = 7;
  // Shortest frame position at CR that can carry a checksum
  localparam int MIN_CS_POS = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_LOW  = 1'd1;
  localparam logic [7:0] STATION_HIGH_RST = 8'd48;
  localparam logic [7:0] STATION_LOW_RST  = 8'd49;

  // Characters
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_W       = 8'h57;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] HEX_NUM_OFS   = 8'h30;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;

  // Poll banks
  localparam logic [1:0] BANK_X = 2'd1;
  localparam logic [1:0] BANK_Y = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_CSUM_BAD    = 4'd0;
  localparam logic [3:0] ST_BAD_ADDR    = 4'd1;
  localparam logic [3:0] ST_CONTACT     = 4'd2;
  localparam logic [3:0] ST_BAD_CONTACT = 4'd3;
  localparam logic [3:0] ST_READ_ACK    = 4'd4;
  localparam logic [3:0] ST_WRITE_ACK   = 4'd5;
  localparam logic [3:0] ST_OTHER_ACK   = 4'd6;
  localparam logic [3:0] ST_ERR_REPLY   = 4'd7;
  localparam logic [3:0] ST_BAD_FORMAT  = 4'd8;

  // One result item
  typedef struct packed {
    logic [3:0] status;
    logic       contact_on;
    logic [1:0] bank;
    logic [5:0] channel;
  } result_t;

  // Contact store write command
  typedef struct packed {
    logic       we;
    logic [1:0] bank;
    logic [5:0] channel;
    logic       value;
  } store_cmd_t;

  // Upper-case hex digit of the low nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    hex_digit = (nib > 4'd9) ? ({4'd0, nib} + HEX_ALPHA_OFS) : ({4'd0, nib} + HEX_NUM_OFS);
  endfunction

endpackage

[rtl/pad_if.sv]
// ----------------------------------------------------------------------------
// pad_if: item channels of the deframer
// Valid/ready channels for received characters and for frame results.
// ----------------------------------------------------------------------------
interface pad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [1:0] poll_bank;
  logic [5:0] poll_channel;

  modport source (output valid, rx_byte, poll_bank, poll_channel, input ready);
  modport sink   (input valid, rx_byte, poll_bank, poll_channel, output ready);
endinterface

interface pad_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       contact_on;
  logic [1:0] bank;
  logic [5:0] channel;

  modport source (output valid, status, contact_on, bank, channel, input ready);
  modport sink   (input valid, status, contact_on, bank, channel, output ready);
endinterface

[rtl/pad_frame.sv]
// ----------------------------------------------------------------------------
// pad_frame: frame tracker and reply decoder
// Keeps header characters, position, running XOR and the last two
// characters; on CR decodes the frame into one result and a store command.
// ----------------------------------------------------------------------------
module pad_frame #(
  parameter int MAX_FRAME = pad_pkg::DEF_MAX_FRAME,
  parameter int CHANNELS  = pad_pkg::DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [1:0]          poll_bank,
  input  logic [5:0]          poll_channel,
  input  logic [7:0]          station_high,
  input  logic [7:0]          station_low,
  output logic                is_cr,
  output pad_pkg::result_t    res,
  output pad_pkg::store_cmd_t store_cmd
);
  import pad_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME - 1);

  logic [POS_W-1:0] pos;
  logic [7:0]       hdr [HDR_LEN];
  logic [7:0]       xacc;
  logic [7:0]       last0;
  logic [7:0]       last1;
  logic [7:0]       hv [HDR_LEN];
  logic             cs_ok;
  logic             ch_in_range;
  logic             v;

  assign is_cr = (rx_byte == CH_CR);

  // Header as seen with the current character placed
  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      hv[i] = (pos == POS_W'(i)) ? rx_byte : hdr[i];
    end
  end

  // Checksum over all but the last two characters
  assign cs_ok = (pos >= POS_W'(MIN_CS_POS)) &&
                 (hex_digit(xacc[7:4]) == last0) &&
                 (hex_digit(xacc[3:0]) == last1);

  assign ch_in_range = ({1'b0, poll_channel} < 7'(CHANNELS));
  assign v = (hv[6] == CH_ONE);

  // Reply decode
  always_comb begin
    res = '0;
    if (!cs_ok) begin
      res.status = ST_CSUM_BAD;
    end else if (hv[0] != CH_PERCENT || hv[1] != station_high || hv[2] != station_low) begin
      res.status = ST_BAD_ADDR;
    end else if (hv[3] == CH_DOLLAR) begin
      if (hv[4] == CH_R && hv[5] == CH_C) begin
        if (hv[6] == CH_ZERO || hv[6] == CH_ONE) begin
          res.status     = ST_CONTACT;
          res.contact_on = v;
          res.bank       = poll_bank;
          res.channel    = poll_channel;
        end else begin
          res.status = ST_BAD_CONTACT;
        end
      end else if (hv[4] == CH_R && hv[5] == CH_D) begin
        res.status = ST_READ_ACK;
      end else if (hv[4] == CH_W && hv[5] == CH_C) begin
        res.status = ST_WRITE_ACK;
      end else begin
        res.status = ST_OTHER_ACK;
      end
    end else if (hv[3] == CH_BANG) begin
      res.status = ST_ERR_REPLY;
    end else begin
      res.status = ST_BAD_FORMAT;
    end
  end

  // Contact store command
  always_comb begin
    store_cmd.we      = step && is_cr && (res.status == ST_CONTACT) && ch_in_range;
    store_cmd.bank    = poll_bank;
    store_cmd.channel = poll_channel;
    store_cmd.value   = v;
  end

  // Frame state; cleared after every CR
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      xacc  <= '0;
      last0 <= '0;
      last1 <= '0;
      for (int i = 0; i < HDR_LEN; i++) hdr[i] <= '0;
    end else if (step) begin
      if (is_cr) begin
        pos   <= '0;
        xacc  <= '0;
        last0 <= '0;
        last1 <= '0;
        for (int i = 0; i < HDR_LEN; i++) hdr[i] <= '0;
      end else begin
        for (int i = 0; i < HDR_LEN; i++) hdr[i] <= hv[i];
        xacc  <= xacc ^ last0;
        last0 <= last1;
        last1 <= rx_byte;
        if (pos < POS_MAX) pos <= pos + 1'b1;
      end
    end
  end

endmodule

[rtl/pad_contacts.sv]
// ----------------------------------------------------------------------------
// pad_contacts: contact state stores
// X, Y and common contact bits, one per channel, cleared at reset.
// ----------------------------------------------------------------------------
module pad_contacts #(
  parameter int CHANNELS = pad_pkg::DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  pad_pkg::store_cmd_t store_cmd
);
  import pad_pkg::*;

  localparam int CH_W = $clog2(CHANNELS);

  logic [CHANNELS-1:0] x_contacts;
  logic [CHANNELS-1:0] y_contacts;
  logic [CHANNELS-1:0] any_contacts;
  logic [CH_W-1:0]     idx;

  assign idx = store_cmd.channel[CH_W-1:0];

  // Store the polled contact; unknown bank writes the common store only
  always_ff @(posedge clk) begin
    if (rst) begin
      x_contacts   <= '0;
      y_contacts   <= '0;
      any_contacts <= '0;
    end else if (store_cmd.we) begin
      if (store_cmd.bank == BANK_X) x_contacts[idx] <= store_cmd.value;
      if (store_cmd.bank == BANK_Y) y_contacts[idx] <= store_cmd.value;
      any_contacts[idx] <= store_cmd.value;
    end
  end

endmodule

[rtl/plc_ascii_response_deframer.sv]
// ----------------------------------------------------------------------------
// plc_ascii_response_deframer: ASCII PLC response deframer
// Input register, frame tracker/decoder, contact stores, result register.
// ----------------------------------------------------------------------------
// Takes one received character per cycle unless a CR stalls. Each character
// is held in the input register, where the frame tracker folds it into the
// header, XOR and position state; a consumed CR produces one result that is
// registered in the result register. Throughput is one character per cycle
// while no CR stalls, set by the update of the frame state; the input stalls
// only when a CR meets a full result register that is not being taken.
// Contact stores clear at reset.
module plc_ascii_response_deframer #(
  parameter int MAX_FRAME = pad_pkg::DEF_MAX_FRAME,
  parameter int CHANNELS  = pad_pkg::DEF_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [pad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pad_pkg::CFG_DATA_W-1:0]  cfg_data,
  pad_in_if.sink                          in_ch,
  pad_out_if.source                       out_ch
);
  import pad_pkg::*;

  logic [7:0] station_high;
  logic [7:0] station_low;

  logic       in_vld;
  logic [7:0] in_byte;
  logic [1:0] in_bank;
  logic [5:0] in_channel;

  logic       out_vld;
  result_t    out_res;

  logic       is_cr;
  logic       out_free;
  logic       consume;
  logic       load;
  result_t    res;
  store_cmd_t store_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      station_high <= STATION_HIGH_RST;
      station_low  <= STATION_LOW_RST;
    end else if (cfg_wen) begin
      if (cfg_index == REG_STATION_HIGH) station_high <= cfg_data;
      if (cfg_index == REG_STATION_LOW)  station_low  <= cfg_data;
    end
  end

  // Handshake
  assign out_free     = !out_vld || out_ch.ready;
  assign consume      = in_vld && (!is_cr || out_free);
  assign load         = consume && is_cr;
  assign in_ch.ready  = !in_vld || consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte    <= in_ch.rx_byte;
      in_bank    <= in_ch.poll_bank;
      in_channel <= in_ch.poll_channel;
    end
  end

  pad_frame #(
    .MAX_FRAME (MAX_FRAME),
    .CHANNELS  (CHANNELS)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (consume),
    .rx_byte      (in_byte),
    .poll_bank    (in_bank),
    .poll_channel (in_channel),
    .station_high (station_high),
    .station_low  (station_low),
    .is_cr        (is_cr),
    .res          (res),
    .store_cmd    (store_cmd)
  );

  pad_contacts #(
    .CHANNELS (CHANNELS)
  ) u_contacts (
    .clk       (clk),
    .rst       (rst),
    .store_cmd (store_cmd)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= res;
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.status     = out_res.status;
  assign out_ch.contact_on = out_res.contact_on;
  assign out_ch.bank       = out_res.bank;
  assign out_ch.channel    = out_res.channel;

  // Checks
  a_rose_after_cr: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(load))
    else $error("result appeared without a consumed CR");

  a_store_only_contact: assert property (@(posedge clk) disable iff (rst)
    store_cmd.we |-> (in_vld && is_cr && res.status == ST_CONTACT))
    else $error("contact store written outside a contact reply");

  a_echo_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_res.status != ST_CONTACT) |->
      (out_res.bank == 2'd0 && out_res.channel == 6'd0 && !out_res.contact_on))
    else $error("non-contact result carries contact fields");

endmodule

[tb/pad_frame_checker.sv]
// ----------------------------------------------------------------------------
// pad_frame_checker: result predictor and scoreboard for the deframer
// Watches the configuration port and both item channels, folds every
// accepted character into its own copy of the frame and contact state, and
// compares each accepted result field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module pad_frame_checker
  import pad_pkg::*;
#(
  parameter int MAX_FRAME = DEF_MAX_FRAME,
  parameter int CHANNELS  = DEF_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pad_in_if                     in_ch,
  pad_out_if                    out_ch,
  output int                    errors,
  output int                    pending
);

  // Station address as last written
  logic [7:0] stn_hi;
  logic [7:0] stn_lo;

  // Frame tracking state
  logic [$clog2(MAX_FRAME)-1:0] pos_q;
  logic [7:0] hdr_q [HDR_LEN];
  logic [7:0] xor_q;
  logic [7:0] tail_q [2];

  // Contact stores
  logic x_store   [CHANNELS];
  logic y_store   [CHANNELS];
  logic any_store [CHANNELS];

  // Results still owed by the block, oldest first
  result_t frames_due [$];
  int      fail_count = 0;
  int      due_count  = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib > 4'd9) ? 8'h37 + {4'd0, nib} : 8'h30 + {4'd0, nib};
  endfunction

  function automatic void clear_frame();
    pos_q = '0;
    foreach (hdr_q[i]) hdr_q[i] = 8'd0;
    xor_q = 8'd0;
    tail_q[0] = 8'd0;
    tail_q[1] = 8'd0;
  endfunction

  // Fold one accepted character; a CR closes the frame and owes one result
  task automatic take_char(input logic [7:0] c, input logic [1:0] pb, input logic [5:0] pc);
    result_t r;
    logic    on;
    if (int'(pos_q) < HDR_LEN) hdr_q[pos_q[2:0]] = c;
    if (c != CH_CR) begin
      xor_q = xor_q ^ tail_q[0];
      tail_q[0] = tail_q[1];
      tail_q[1] = c;
      if (int'(pos_q) < MAX_FRAME - 1) pos_q = pos_q + 1'b1;
    end else begin
      r = '0;
      if (int'(pos_q) < MIN_CS_POS || hex_char(xor_q[7:4]) != tail_q[0] ||
          hex_char(xor_q[3:0]) != tail_q[1]) begin
        r.status = ST_CSUM_BAD;
      end else if (hdr_q[0] != CH_PERCENT || hdr_q[1] != stn_hi || hdr_q[2] != stn_lo) begin
        r.status = ST_BAD_ADDR;
      end else if (hdr_q[3] == CH_DOLLAR) begin
        if (hdr_q[4] == CH_R && hdr_q[5] == CH_C) begin
          if (hdr_q[6] == CH_ZERO || hdr_q[6] == CH_ONE) begin
            on = (hdr_q[6] == CH_ONE);
            if (int'(pc) < CHANNELS) begin
              if (pb == BANK_X) x_store[pc] = on;
              else if (pb == BANK_Y) y_store[pc] = on;
              any_store[pc] = on;
            end
            r.status     = ST_CONTACT;
            r.contact_on = on;
            r.bank       = pb;
            r.channel    = pc;
          end else begin
            r.status = ST_BAD_CONTACT;
          end
        end else if (hdr_q[4] == CH_R && hdr_q[5] == CH_D) begin
          r.status = ST_READ_ACK;
        end else if (hdr_q[4] == CH_W && hdr_q[5] == CH_C) begin
          r.status = ST_WRITE_ACK;
        end else begin
          r.status = ST_OTHER_ACK;
        end
      end else if (hdr_q[3] == CH_BANG) begin
        r.status = ST_ERR_REPLY;
      end else begin
        r.status = ST_BAD_FORMAT;
      end
      frames_due.push_back(r);
      clear_frame();
    end
  endtask

  task automatic report_field(input string what, input logic [7:0] want, input logic [7:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    result_t want;
    if (frames_due.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, got status %0h on %0b bank %0h ch %0h",
               $time, out_ch.status, out_ch.contact_on, out_ch.bank, out_ch.channel);
    end else begin
      want = frames_due.pop_front();
      if (out_ch.status !== want.status)
        report_field("status", 8'(want.status), 8'(out_ch.status));
      if (out_ch.contact_on !== want.contact_on)
        report_field("contact_on", 8'(want.contact_on), 8'(out_ch.contact_on));
      if (out_ch.bank !== want.bank)
        report_field("bank", 8'(want.bank), 8'(out_ch.bank));
      if (out_ch.channel !== want.channel)
        report_field("channel", 8'(want.channel), 8'(out_ch.channel));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stn_hi = STATION_HIGH_RST;
      stn_lo = STATION_LOW_RST;
      clear_frame();
      foreach (x_store[i]) begin
        x_store[i]   = 1'b0;
        y_store[i]   = 1'b0;
        any_store[i] = 1'b0;
      end
      frames_due.delete();
      due_count = 0;
    end else begin
      // register writes
      if (cfg_wen) begin
        if (cfg_index == REG_STATION_HIGH) stn_hi = cfg_data;
        else if (cfg_index == REG_STATION_LOW) stn_lo = cfg_data;
      end
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready)
        take_char(in_ch.rx_byte, in_ch.poll_bank, in_ch.poll_channel);
      due_count = frames_due.size();
    end
  end

endmodule

[tb/tb_plc_ascii_response_deframer.sv]
// ----------------------------------------------------------------------------
// tb_plc_ascii_response_deframer: testbench top of the response deframer
// Builds response frames (contact replies, acks, error replies and broken
// frames of every kind), sends them character by character in random
// bursts under several station addresses, and lets the checker score the
// results while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_plc_ascii_response_deframer;
  import pad_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 4;
  localparam int PHASE_CHARS = 100;
  localparam logic [1:0] BANK_NONE  = 2'd0;
  localparam logic [1:0] BANK_SPARE = 2'd3;

  typedef enum int {
    FR_CONTACT, FR_READ, FR_WRITE, FR_OTHER, FR_ERROR, FR_FORMAT,
    FR_ADDR, FR_CSUM, FR_BADCHAR, FR_SHORT, FR_NOISE, FR_LONG
  } frame_kind_e;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    cycle_count = 0;
  int                    burst_left = 0;
  int                    chars_sent = 0;
  logic [7:0]            addr_hi = STATION_HIGH_RST;
  logic [7:0]            addr_lo = STATION_LOW_RST;
  logic [7:0]            frame_buf [$];

  pad_in_if  in_ch ();
  pad_out_if out_ch ();

  plc_ascii_response_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pad_frame_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .pending   (pending)
  );

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: ready follows a randomly chosen mode, picked anew after each run
  initial begin : rx_pace
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 80);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 1) == 1);
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = ((left % 12) == 0);
      endcase
    end
  end

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib > 4'd9) ? HEX_ALPHA_OFS + {4'd0, nib} : HEX_NUM_OFS + {4'd0, nib};
  endfunction

  // Random character other than CR
  function automatic logic [7:0] any_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
    return c;
  endfunction

  // Random character other than CR and the given one
  function automatic logic [7:0] other_char(input logic [7:0] avoid);
    logic [7:0] c;
    do c = any_char(); while (c == avoid);
    return c;
  endfunction

  // Append the two checksum digits and CR, optionally spoiling one digit
  function automatic void seal_frame(input bit spoil);
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = 8'd0;
    foreach (frame_buf[i]) sum ^= frame_buf[i];
    hi = hex_ascii(sum[7:4]);
    lo = hex_ascii(sum[3:0]);
    if (spoil) begin
      if ($urandom_range(0, 1) == 1) hi = other_char(hi);
      else lo = other_char(lo);
    end
    frame_buf.push_back(hi);
    frame_buf.push_back(lo);
    frame_buf.push_back(CH_CR);
  endfunction

  function automatic void build_frame(input frame_kind_e kind);
    int         extra;
    int         slot;
    logic [7:0] c;
    frame_buf = {};
    if (kind == FR_SHORT) begin
      repeat ($urandom_range(0, 2)) frame_buf.push_back(any_char());
      frame_buf.push_back(CH_CR);
      return;
    end
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(CH_CR);
      return;
    end
    frame_buf.push_back(CH_PERCENT);
    frame_buf.push_back(addr_hi);
    frame_buf.push_back(addr_lo);
    if (kind == FR_ADDR) begin
      slot = $urandom_range(0, 2);
      frame_buf[slot] = other_char(frame_buf[slot]);
    end
    case (kind)
      FR_ERROR: begin
        frame_buf.push_back(CH_BANG);
        frame_buf.push_back(any_char());
        frame_buf.push_back(any_char());
      end
      FR_FORMAT: begin
        do c = any_char(); while (c == CH_DOLLAR || c == CH_BANG);
        frame_buf.push_back(c);
        frame_buf.push_back(any_char());
        frame_buf.push_back(any_char());
      end
      FR_READ: frame_buf = {frame_buf, CH_DOLLAR, CH_R, CH_D};
      FR_WRITE: frame_buf = {frame_buf, CH_DOLLAR, CH_W, CH_C};
      FR_OTHER: frame_buf = {frame_buf, CH_DOLLAR, any_char(), any_char()};
      FR_BADCHAR: begin
        do c = any_char(); while (c == CH_ZERO || c == CH_ONE);
        frame_buf = {frame_buf, CH_DOLLAR, CH_R, CH_C, c};
      end
      default: begin
        c = ($urandom_range(0, 1) == 1) ? CH_ONE : CH_ZERO;
        frame_buf = {frame_buf, CH_DOLLAR, CH_R, CH_C, c};
      end
    endcase
    extra = (kind == FR_LONG) ? $urandom_range(125, 140) : $urandom_range(0, 6);
    repeat (extra) frame_buf.push_back(any_char());
    seal_frame(kind == FR_CSUM);
  endfunction

  // One item: bursts of random length with random gaps in between
  task automatic send_char(input logic [7:0] c, input logic [1:0] pb, input logic [5:0] pc);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid        = 1'b1;
    in_ch.rx_byte      = c;
    in_ch.poll_bank    = pb;
    in_ch.poll_channel = pc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  // Send frame_buf; the closing character carries the given poll target
  task automatic send_frame(input logic [1:0] pb, input logic [5:0] pc);
    foreach (frame_buf[i]) begin
      if (i == frame_buf.size() - 1) send_char(frame_buf[i], pb, pc);
      else send_char(frame_buf[i], 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
    end
  endtask

  task automatic frame_out(input frame_kind_e kind, input logic [1:0] pb, input logic [5:0] pc);
    build_frame(kind);
    send_frame(pb, pc);
  endtask

  // Hold the sender until every owed result has come out
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_station(input logic [7:0] hi, input logic [7:0] lo);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = REG_STATION_HIGH;
    cfg_data  = hi;
    @(negedge clk);
    cfg_index = REG_STATION_LOW;
    cfg_data  = lo;
    @(negedge clk);
    cfg_wen   = 1'b0;
    addr_hi   = hi;
    addr_lo   = lo;
  endtask

  function automatic logic [7:0] station_char();
    return any_char();
  endfunction

  task automatic random_frame();
    int          pick;
    frame_kind_e kind;
    pick = $urandom_range(0, 99);
    if (pick < 30) kind = FR_CONTACT;
    else if (pick < 36) kind = FR_READ;
    else if (pick < 42) kind = FR_WRITE;
    else if (pick < 48) kind = FR_OTHER;
    else if (pick < 54) kind = FR_ERROR;
    else if (pick < 60) kind = FR_FORMAT;
    else if (pick < 68) kind = FR_ADDR;
    else if (pick < 76) kind = FR_CSUM;
    else if (pick < 82) kind = FR_BADCHAR;
    else if (pick < 88) kind = FR_SHORT;
    else if (pick < 98) kind = FR_NOISE;
    else kind = FR_LONG;
    frame_out(kind, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
    if ($urandom_range(0, 19) == 0) drain();
  endtask

  task automatic random_phase();
    int start;
    start = chars_sent;
    while (chars_sent - start < PHASE_CHARS) random_frame();
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    rst                = 1'b1;
    cfg_wen            = 1'b0;
    cfg_index          = REG_STATION_HIGH;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.rx_byte      = 8'd0;
    in_ch.poll_bank    = BANK_NONE;
    in_ch.poll_channel = 6'd0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: contact replies on every bank code and channel extremes
    frame_out(FR_CONTACT, BANK_X, 6'd63);
    frame_out(FR_CONTACT, BANK_Y, 6'd0);
    frame_out(FR_CONTACT, BANK_NONE, 6'd21);
    frame_out(FR_CONTACT, BANK_SPARE, 6'd42);
    frame_out(FR_READ, BANK_X, 6'd5);
    frame_out(FR_WRITE, BANK_Y, 6'd6);
    frame_out(FR_OTHER, BANK_X, 6'd7);
    frame_out(FR_ERROR, BANK_Y, 6'd8);
    frame_out(FR_FORMAT, BANK_X, 6'd9);
    frame_out(FR_ADDR, BANK_X, 6'd10);
    frame_out(FR_CSUM, BANK_X, 6'd11);
    frame_out(FR_BADCHAR, BANK_Y, 6'd12);
    // bare CR, then a frame that is too short for a checksum
    frame_buf = {CH_CR};
    send_frame(BANK_X, 6'd13);
    frame_out(FR_SHORT, BANK_Y, 6'd14);
    // shortest frame with a valid checksum
    frame_buf = {8'h00};
    seal_frame(1'b0);
    send_frame(BANK_X, 6'd15);
    // CR lands inside the header positions
    frame_buf = {CH_PERCENT, addr_hi, addr_lo, CH_DOLLAR};
    seal_frame(1'b0);
    send_frame(BANK_Y, 6'd16);
    // position saturates, checksum still covers everything
    frame_out(FR_LONG, BANK_X, 6'd17);
    drain();

    // random traffic under several station addresses
    random_phase();
    drain();
    set_station(8'h00, 8'hFF);
    random_phase();
    drain();
    set_station(8'hFF, 8'h00);
    random_phase();
    drain();
    set_station(station_char(), station_char());
    random_phase();
    drain();
    set_station(STATION_HIGH_RST, STATION_LOW_RST);
    random_phase();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
